@@ src/sbs_pkg.sv @@
package sbs_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 10;
  localparam int ECNT_W  = 11;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_EXACT = 2'd1,
    FN_LEFT  = 2'd2,
    FN_RIGHT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                    func;
    logic [IDX_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]  entry_value;
    logic signed [VAL_W-1:0]  search_key;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_index;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VAL_W-1:0]   wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

endpackage

@@ src/sbs_ram.sv @@
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sbs_search.sv @@
module sbs_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sbs_pkg::in_word_t          in_data,
  input  logic [sbs_pkg::ECNT_W-1:0] entry_count,
  output sbs_pkg::ram_req_t          ram_req,
  input  logic [sbs_pkg::VAL_W-1:0]  ram_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sbs_pkg::out_word_t         out_data
);

  sbs_pkg::state_t state, state_next;

  logic [sbs_pkg::CNT_W-1:0]  lo, lo_next;
  logic [sbs_pkg::CNT_W-1:0]  hi, hi_next;
  logic [sbs_pkg::ADDR_W-1:0] mid, mid_next;
  sbs_pkg::func_t             func, func_next;
  logic signed [sbs_pkg::VAL_W-1:0] key, key_next;
  logic                       res_found, res_found_next;
  logic [sbs_pkg::IDX_W-1:0]  res_index, res_index_next;

  logic                       accept;
  logic                       is_query;
  logic                       slot_free;
  logic [sbs_pkg::CNT_W-1:0]  n;
  logic [sbs_pkg::CNT_W-1:0]  mid_ext;
  logic signed [sbs_pkg::VAL_W-1:0] v;
  logic                       lt, eq, go_right, exact_hit, more, no_final;
  logic [sbs_pkg::CNT_W-1:0]  lo_p, hi_p;
  logic [sbs_pkg::ADDR_W-1:0] final_addr;

  function automatic logic [sbs_pkg::ADDR_W-1:0] mid_of(
    input logic [sbs_pkg::CNT_W-1:0] l,
    input logic [sbs_pkg::CNT_W-1:0] h,
    input logic                      closed
  );
    logic [sbs_pkg::CNT_W-1:0] span;
    span = closed ? (h - l - sbs_pkg::CNT_W'(1)) : (h - l);
    return sbs_pkg::ADDR_W'(l + (span >> 1));
  endfunction

  assign accept    = in_valid && !in_stall;
  assign is_query  = (in_data.func != sbs_pkg::FN_WRITE);
  assign slot_free = !out_valid || !out_stall;
  assign n = (32'(entry_count) > sbs_pkg::DEPTH) ? sbs_pkg::CNT_W'(sbs_pkg::DEPTH)
                                                   : sbs_pkg::CNT_W'(entry_count);

  // Probe evaluation: the word read for mid is on ram_rdata in ST_PROBE
  assign mid_ext   = sbs_pkg::CNT_W'(mid);
  assign v         = $signed(ram_rdata);
  assign lt        = v < key;
  assign eq        = v == key;
  assign go_right  = (func == sbs_pkg::FN_RIGHT) ? (lt || eq) : lt;
  assign exact_hit = (func == sbs_pkg::FN_EXACT) && eq;
  assign lo_p      = go_right ? (mid_ext + sbs_pkg::CNT_W'(1)) : lo;
  assign hi_p      = go_right ? hi : mid_ext;
  assign more      = lo_p < hi_p;
  assign no_final  = (func == sbs_pkg::FN_EXACT) ||
                     ((func == sbs_pkg::FN_LEFT) && (lo_p >= n)) ||
                     ((func == sbs_pkg::FN_RIGHT) && (lo_p == '0));
  assign final_addr = (func == sbs_pkg::FN_RIGHT) ? sbs_pkg::ADDR_W'(lo_p - sbs_pkg::CNT_W'(1))
                                                  : sbs_pkg::ADDR_W'(lo_p);

  always_comb begin
    state_next = state;
    case (state)
      sbs_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          state_next = (n == '0) ? sbs_pkg::ST_DONE : sbs_pkg::ST_PROBE;
        end
      end
      sbs_pkg::ST_PROBE: begin
        if (exact_hit) begin
          state_next = sbs_pkg::ST_DONE;
        end else if (more) begin
          state_next = sbs_pkg::ST_PROBE;
        end else if (no_final) begin
          state_next = sbs_pkg::ST_DONE;
        end else begin
          state_next = sbs_pkg::ST_FINAL;
        end
      end
      sbs_pkg::ST_FINAL: state_next = sbs_pkg::ST_DONE;
      sbs_pkg::ST_DONE: begin
        if (slot_free) begin
          state_next = sbs_pkg::ST_IDLE;
        end
      end
      default: state_next = sbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != sbs_pkg::ST_IDLE);
    ram_req.we     = 1'b0;
    ram_req.waddr  = sbs_pkg::ADDR_W'(in_data.entry_index);
    ram_req.wdata  = in_data.entry_value;
    ram_req.raddr  = mid;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    func_next      = func;
    key_next       = key;
    res_found_next = res_found;
    res_index_next = res_index;
    case (state)
      sbs_pkg::ST_IDLE: begin
        if (accept && !is_query) begin
          ram_req.we = (32'(in_data.entry_index) < sbs_pkg::DEPTH);
        end
        if (accept && is_query) begin
          lo_next        = '0;
          hi_next        = n;
          func_next      = in_data.func;
          key_next       = in_data.search_key;
          mid_next       = mid_of('0, n, in_data.func == sbs_pkg::FN_EXACT);
          ram_req.raddr  = mid_next;
          res_found_next = 1'b0;
          res_index_next = '0;
        end
      end
      sbs_pkg::ST_PROBE: begin
        lo_next = lo_p;
        hi_next = hi_p;
        if (exact_hit) begin
          res_found_next = 1'b1;
          res_index_next = sbs_pkg::IDX_W'(mid);
        end else if (more) begin
          mid_next      = mid_of(lo_p, hi_p, func == sbs_pkg::FN_EXACT);
          ram_req.raddr = mid_next;
        end else if (no_final) begin
          res_found_next = 1'b0;
          res_index_next = '0;
        end else begin
          mid_next      = final_addr;
          ram_req.raddr = final_addr;
        end
      end
      sbs_pkg::ST_FINAL: begin
        res_found_next = eq;
        res_index_next = eq ? sbs_pkg::IDX_W'(mid) : '0;
      end
      sbs_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sbs_pkg::ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    func      <= func_next;
    key       <= key_next;
    res_found <= res_found_next;
    res_index <= res_index_next;
    if (state == sbs_pkg::ST_DONE && slot_free) begin
      out_data.found       <= res_found;
      out_data.match_index <= res_index;
    end
  end

endmodule

@@ src/sorted_table_binary_search_top.sv @@
// Sorted-table binary search over a table of signed 32-bit words.
//
// Input channel (in_valid / in_stall / in_data): one word per item. func
// FN_WRITE stores entry_value at entry_index and gives no result; the other
// funcs search the first entry_count entries for search_key (exact match,
// lowest index, highest index) and give one result word on the output
// channel (out_valid / out_stall / out_data): found and match_index, the
// index being 0 when found is 0.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes entry_count;
// cfg_ready is always high. Values above the table depth saturate.
//
// A write leaves the engine idle for the next item. A query issues one
// table read per halving step from the single read port of the table RAM;
// the next item is taken the cycle after the result is loaded into the
// output register.
// A result waiting under out_stall holds in the output register while the
// next item is accepted; a second result then waits inside the engine.
// Reset clears entry_count and the control state; table contents are
// undefined until written.
module sorted_table_binary_search_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sbs_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sbs_pkg::out_word_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sbs_pkg::ECNT_W-1:0] cfg_data
);

  logic [sbs_pkg::ECNT_W-1:0] entry_count;
  sbs_pkg::ram_req_t          ram_req;
  logic [sbs_pkg::VAL_W-1:0]  ram_rdata;

  // Take every config word at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Table storage: write port from write items, read port driven by the
  // probe address of the search engine
  sbs_ram #(
    .WIDTH (sbs_pkg::VAL_W),
    .DEPTH (sbs_pkg::DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Search sequencer: one probe per cycle, output register at the end
  sbs_search u_search (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .entry_count (entry_count),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

@@ src/sbs_checker.sv @@
module sbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input sbs_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input sbs_pkg::out_word_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A miss reports index 0
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_index == '0)
    else $error("miss with nonzero index");

  // A query occupies the engine for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.func != sbs_pkg::FN_WRITE |=> in_stall)
    else $error("query not holding off input");

  // Writes stream back to back
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.func == sbs_pkg::FN_WRITE |=> !in_stall)
    else $error("write blocked input");

endmodule

bind sorted_table_binary_search_top sbs_checker u_sbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbs_pkg::*;

  localparam int GAP_MAX      = 18;    // longest idle run on either side
  localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving before giving up
  localparam int SETTLE       = 20;    // engine drain time
  localparam int RANDOM_ITEMS = 1250;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [ECNT_W-1:0]       COUNT_TOP = '1;

  // Mirror of the table and entry count; turns each accepted input word into
  // the answer the block owes and keeps the answers in arrival order.
  class search_mirror;
    logic signed [VAL_W-1:0] words [DEPTH];
    int          span;          // entries searched, already clipped to DEPTH
    out_word_t   answers_due [$];
    int          mismatches;

    function new();
      span       = 0;
      mismatches = 0;
    endfunction

    function void set_count(logic [ECNT_W-1:0] c);
      span = (c > DEPTH) ? DEPTH : int'(c);
    endfunction

    // Closed interval, stop at the first probe that hits.
    function int exact_probe(logic signed [VAL_W-1:0] key);
      int lo, hi, mid;
      lo = 0;
      hi = span;
      while (lo < hi) begin
        mid = lo + (hi - 1 - lo) / 2;
        if (words[mid] == key) return mid;
        if (words[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return -1;
    endfunction

    // Half-open lower bound: first slot not below the key.
    function int lowest_hit(logic signed [VAL_W-1:0] key);
      int lo, hi, mid;
      lo = 0;
      hi = span;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (words[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      if (lo >= span || words[lo] != key) return -1;
      return lo;
    endfunction

    // Half-open upper bound: last slot not above the key.
    function int highest_hit(logic signed [VAL_W-1:0] key);
      int lo, hi, mid;
      lo = 0;
      hi = span;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (words[mid] <= key) lo = mid + 1;
        else hi = mid;
      end
      if (lo == 0 || words[lo-1] != key) return -1;
      return lo - 1;
    endfunction

    function void note_word(in_word_t w);
      out_word_t ans;
      int        pos;
      if (w.func == FN_WRITE) begin
        words[w.entry_index] = w.entry_value;
        return;
      end
      case (w.func)
        FN_EXACT: pos = exact_probe(w.search_key);
        FN_LEFT:  pos = lowest_hit(w.search_key);
        default:  pos = highest_hit(w.search_key);
      endcase
      ans.found       = (pos >= 0);
      ans.match_index = (pos >= 0) ? pos[IDX_W-1:0] : '0;
      answers_due.push_back(ans);
    endfunction

    function void complain(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_answer(out_word_t got);
      out_word_t want;
      if (answers_due.size() == 0) begin
        complain("unexpected result word (found)", -1, int'(got.found));
        return;
      end
      want = answers_due.pop_front();
      if (got.found !== want.found)
        complain("found", int'(want.found), int'(got.found));
      if (got.match_index !== want.match_index)
        complain("match_index", int'(want.match_index), int'(got.match_index));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ECNT_W-1:0]   cfg_data;

  search_mirror mirror;
  bit           no_idle;      // set per phase: both sides run back to back
  int           items_sent;
  int           idle_cycles;

  sorted_table_binary_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Build a table write; the unused key field carries noise.
  function automatic in_word_t store_word(int idx, logic signed [VAL_W-1:0] v);
    in_word_t w;
    w.func        = FN_WRITE;
    w.entry_index = idx[IDX_W-1:0];
    w.entry_value = v;
    w.search_key  = $urandom;
    return w;
  endfunction

  // Build a search; index and value fields carry noise.
  function automatic in_word_t query_word(func_t f, logic signed [VAL_W-1:0] key);
    in_word_t w;
    w.func        = f;
    w.entry_index = IDX_W'($urandom);
    w.entry_value = $urandom;
    w.search_key  = key;
    return w;
  endfunction

  // Offer one input word after a random gap; called and returns at a falling
  // edge. A back-to-back word keeps valid high and only swaps the payload.
  task automatic push_word(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror.note_word(w);
    items_sent++;
    @(negedge clk);
  endtask

  // Write entry_count with the engine quiet: drain owed answers, then let a
  // trailing table write or search finish before touching the register.
  task automatic load_entry_count(int c);
    in_valid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ECNT_W'(c);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    mirror.set_count(ECNT_W'(c));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load slots 0..n-1 with an ascending run: plenty of repeats so the bound
  // searches have runs to walk, plus jumps of up to max_step.
  task automatic fill_sorted(int n, longint start, longint max_step);
    longint v;
    int     r;
    v = start;
    for (int i = 0; i < n; i++) begin
      push_word(store_word(i, v[VAL_W-1:0]));
      r = $urandom_range(0, 9);
      if (r >= 3)
        v += (r < 7) ? longint'($urandom_range(1, 3)) : longint'($urandom_range(1, max_step));
      if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
    end
  endtask

  // Searches over the live table, mostly for keys that sit in it or just
  // beside one, with a few stray table writes mixed in to break the order.
  task automatic query_burst(int count);
    logic signed [VAL_W-1:0] key;
    int                      r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_word(store_word($urandom_range(0, DEPTH-1), $urandom));
      end else begin
        r   = $urandom_range(0, 9);
        key = $urandom;
        if (mirror.span > 0 && r < 8) begin
          key = mirror.words[$urandom_range(0, mirror.span-1)];
          if (r == 6) key = key + 1;
          if (r == 7) key = key - 1;
        end else if (r == 8) begin
          key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        end
        push_word(query_word(func_t'($urandom_range(1, 3)), key));
      end
    end
  endtask

  // Receiver: hold stall for a random count, then drop it until a result
  // word is taken, and draw again.
  initial begin
    int hold;
    out_stall = 1'b1;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Check every result word taken at a rising edge.
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      mirror.check_answer(out_data);
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic signed [VAL_W-1:0] ladder [8];
    int                      phase_no;
    int                      n;
    int                      start_items;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    no_idle    = 1'b0;
    items_sent = 0;
    mirror     = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: every search must miss.
    load_entry_count(0);
    push_word(query_word(FN_EXACT, 0));
    push_word(query_word(FN_LEFT, VAL_MIN));
    push_word(query_word(FN_RIGHT, VAL_MAX));

    // Short table with both value extremes and a run of repeats in the middle.
    ladder = '{VAL_MIN, VAL_MIN, -1, 0, 0, 0, 5, VAL_MAX};
    for (int i = 0; i < 8; i++)
      push_word(store_word(i, ladder[i]));
    load_entry_count(8);
    push_word(query_word(FN_EXACT, 0));
    push_word(query_word(FN_LEFT, 0));
    push_word(query_word(FN_RIGHT, 0));
    push_word(query_word(FN_LEFT, VAL_MIN));
    push_word(query_word(FN_RIGHT, VAL_MIN));
    push_word(query_word(FN_EXACT, VAL_MAX));
    push_word(query_word(FN_RIGHT, VAL_MAX));
    push_word(query_word(FN_LEFT, 3));        // falls between entries
    push_word(query_word(FN_EXACT, -1));
    push_word(query_word(FN_RIGHT, 6));

    // One live entry: hit at slot 0, miss above it.
    load_entry_count(1);
    push_word(query_word(FN_EXACT, VAL_MIN));
    push_word(query_word(FN_RIGHT, VAL_MAX));

    // Break the order and search anyway; the probes decide the answer.
    load_entry_count(8);
    push_word(store_word(3, VAL_MAX));
    push_word(query_word(FN_LEFT, 0));
    push_word(query_word(FN_EXACT, 0));

    // Random phases: refill a prefix, set the count, search. Phase 2 fills the
    // whole table, searches it at full depth and then with a count past it.
    phase_no    = 0;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        fill_sorted(DEPTH, longint'(VAL_MIN) + $urandom_range(0, 1000), 64'd1 << 24);
        load_entry_count(DEPTH);
        query_burst(80);
        load_entry_count(int'(COUNT_TOP));
        query_burst(40);
        load_entry_count($urandom_range(DEPTH + 1, COUNT_TOP - 1));
        query_burst(20);
      end else begin
        if ($urandom_range(0, 9) == 0)
          n = 0;
        else if ($urandom_range(0, 4) == 0)
          n = $urandom_range(49, 300);
        else
          n = $urandom_range(1, 48);
        ladder[0] = $urandom;
        fill_sorted(n, longint'(ladder[0]), 64'd1 << 16);
        load_entry_count(n);
        query_burst((2 * n + 8 > 120) ? 120 : 2 * n + 8);
      end
      phase_no++;
    end

    // Drain: wait out the owed answers, then give the engine time to show
    // anything extra.
    in_valid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mirror.mismatches == 0 && mirror.answers_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
